>>> sv/dirichlet_convolution_engine_core_macros.svh
// assertion macros for the dirichlet convolution engine core
// no dependencies; included by the top level
`ifndef DIRICHLET_CONVOLUTION_ENGINE_CORE_MACROS_SVH
`define DIRICHLET_CONVOLUTION_ENGINE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define DCE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dce check failed");

// next-cycle implication, disabled during reset
`define DCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dce check failed");

`endif

>>> sv/dce_pkg.sv
// shared types for the dirichlet convolution engine
// no dependencies; used by dce_mac and the top level
`default_nettype none

package dce_pkg;

   localparam int DataWidth = 32;

   typedef struct packed {
      logic signed [DataWidth-1:0] f_value;
      logic signed [DataWidth-1:0] g_value;
      logic                        last_pair;
   } req_word_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] h_value;
      logic                        last_result;
   } rsp_word_type;

   typedef struct packed {
      logic load_first;   // capture f[i]*g[j]
      logic load_second;  // capture f[j]*g[i]
      logic first_pass;   // i == 1: entry not yet accumulated
      logic single_term;  // i == j: only one product
   } mac_ctrl_type;

endpackage

`default_nettype wire

>>> sv/dce_mac.sv
// shared multiplier and accumulate adder for the convolution terms
// depends on dce_pkg
`default_nettype none

module dce_mac (
   input  wire logic                             clock,
   input  wire dce_pkg::mac_ctrl_type            ctrl,
   input  wire logic [dce_pkg::DataWidth-1:0]    f_rd,
   input  wire logic [dce_pkg::DataWidth-1:0]    g_rd,
   input  wire logic [dce_pkg::DataWidth-1:0]    h_rd,
   output logic      [dce_pkg::DataWidth-1:0]    acc_sum
);

   logic [dce_pkg::DataWidth-1:0] prod;
   logic [dce_pkg::DataWidth-1:0] p1_ff;
   logic [dce_pkg::DataWidth-1:0] p2_ff;
   logic [dce_pkg::DataWidth-1:0] base;
   logic [dce_pkg::DataWidth-1:0] second;

   // low word only, arithmetic wraps
   assign prod = dce_pkg::DataWidth'(f_rd * g_rd);

   always_ff @(posedge clock) begin
      if (ctrl.load_first) begin
         p1_ff <= prod;
      end
      if (ctrl.load_second) begin
         p2_ff <= prod;
      end
   end

   always_comb begin
      base    = ctrl.first_pass  ? '0 : h_rd;
      second  = ctrl.single_term ? '0 : p2_ff;
      acc_sum = base + p1_ff + second;
   end

endmodule

`default_nettype wire

>>> sv/dirichlet_convolution_engine_core.sv
// dirichlet convolution engine: load, divisor-pair walk and result emit
// depends on dce_pkg, dce_mac and dirichlet_convolution_engine_core_macros.svh
//
// Pairs f[k], g[k] are taken one per cycle while busy is low; a pair beyond
// MAX_LEN is dropped. The pair flagged last_pair sets n and raises busy. The
// block then visits every divisor pair (i, j) with i <= j and i*j <= n,
// passing through S_RD1, S_RD2, S_MUL2 and S_ACC on each: the f and g
// stores have one read port, so the two products f[i]*g[j] and f[j]*g[i]
// are read and multiplied one after the other on a single multiplier, then
// added into the h store. After the walk, h[1..n] leave back to back, one
// word per cycle on rsp_valid, last word flagged; the receiver cannot stall
// and needs no space beyond one word a cycle. Busy drops with the final
// word. The walk covers P(n) divisor pairs (144 for n = 64). The h store
// needs no clearing pass: the i = 1 pass writes every entry 1..n before
// any later pass reads it.
`default_nettype none

module dirichlet_convolution_engine_core #(
   parameter int MAX_LEN = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire dce_pkg::req_word_type req_data,
   output logic                       rsp_valid,
   output dce_pkg::rsp_word_type      rsp_data
);

   localparam int CountWidth = $clog2(MAX_LEN + 1);
   localparam int AddrWidth  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LoopWidth  = CountWidth + 2;
   localparam int DW         = dce_pkg::DataWidth;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD1,
      S_RD2,
      S_MUL2,
      S_ACC,
      S_EMIT
   } state_type;

   state_type              state_ff;
   logic                   busy_ff;
   logic [CountWidth-1:0]  count_ff;
   logic [CountWidth-1:0]  n_ff;
   logic [LoopWidth-1:0]   i_ff;
   logic [LoopWidth-1:0]   j_ff;
   logic [LoopWidth-1:0]   x_ff;
   logic [LoopWidth-1:0]   sq_ff;
   logic [AddrWidth-1:0]   k_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_last_ff;

   logic [DW-1:0] f_mem [MAX_LEN];
   logic [DW-1:0] g_mem [MAX_LEN];
   logic [DW-1:0] h_mem [MAX_LEN];
   logic [DW-1:0] f_rd_ff;
   logic [DW-1:0] g_rd_ff;
   logic [DW-1:0] h_rd_ff;

   logic                  accept;
   logic                  full;
   logic [LoopWidth-1:0]  i_m1;
   logic [LoopWidth-1:0]  j_m1;
   logic [LoopWidth-1:0]  x_m1;
   logic [AddrWidth-1:0]  f_raddr;
   logic [AddrWidth-1:0]  g_raddr;
   logic [AddrWidth-1:0]  h_raddr;
   logic [LoopWidth-1:0]  n_wide;
   logic [LoopWidth-1:0]  x_in;
   logic [LoopWidth-1:0]  sq_in;
   logic [LoopWidth-1:0]  i_in;
   logic                  emit_last;
   logic [DW-1:0]         acc_sum;
   dce_pkg::mac_ctrl_type mac_ctrl;

   assign accept = start && !busy_ff;
   assign full   = (count_ff == CountWidth'(MAX_LEN));
   assign i_m1   = i_ff - LoopWidth'(1);
   assign j_m1   = j_ff - LoopWidth'(1);
   assign x_m1   = x_ff - LoopWidth'(1);
   assign n_wide = LoopWidth'(n_ff);
   assign x_in   = x_ff + i_ff;
   // (i+1)^2 from i^2
   assign sq_in  = sq_ff + {i_ff[LoopWidth-2:0], 1'b0} + LoopWidth'(1);
   assign i_in   = i_ff + LoopWidth'(1);
   assign emit_last = ((CountWidth'(k_ff) + CountWidth'(1)) == n_ff);

   // read address selection
   always_comb begin
      f_raddr = i_m1[AddrWidth-1:0];
      g_raddr = j_m1[AddrWidth-1:0];
      h_raddr = x_m1[AddrWidth-1:0];
      case (state_ff)
         S_RD2: begin
            f_raddr = j_m1[AddrWidth-1:0];
            g_raddr = i_m1[AddrWidth-1:0];
         end
         S_EMIT: begin
            h_raddr = k_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      mac_ctrl.load_first  = (state_ff == S_RD2);
      mac_ctrl.load_second = (state_ff == S_MUL2);
      mac_ctrl.first_pass  = (i_ff == LoopWidth'(1));
      mac_ctrl.single_term = (i_ff == j_ff);
   end

   dce_mac u_mac (
      .clock   (clock),
      .ctrl    (mac_ctrl),
      .f_rd    (f_rd_ff),
      .g_rd    (g_rd_ff),
      .h_rd    (h_rd_ff),
      .acc_sum (acc_sum)
   );

   // operand stores
   always_ff @(posedge clock) begin
      if (accept && !full) begin
         f_mem[count_ff[AddrWidth-1:0]] <= req_data.f_value;
         g_mem[count_ff[AddrWidth-1:0]] <= req_data.g_value;
      end
      f_rd_ff <= f_mem[f_raddr];
      g_rd_ff <= g_mem[g_raddr];
   end

   // result store
   always_ff @(posedge clock) begin
      if (state_ff == S_ACC) begin
         h_mem[x_m1[AddrWidth-1:0]] <= acc_sum;
      end
      h_rd_ff <= h_mem[h_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         n_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         x_ff         <= '0;
         sq_ff        <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_EMIT);
         rsp_last_ff  <= (state_ff == S_EMIT) && emit_last;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (!full) begin
                     count_ff <= count_ff + CountWidth'(1);
                  end
                  if (req_data.last_pair) begin
                     n_ff     <= full ? count_ff : count_ff + CountWidth'(1);
                     i_ff     <= LoopWidth'(1);
                     j_ff     <= LoopWidth'(1);
                     x_ff     <= LoopWidth'(1);
                     sq_ff    <= LoopWidth'(1);
                     busy_ff  <= 1'b1;
                     state_ff <= S_RD1;
                  end
               end
            end
            S_RD1: begin
               state_ff <= S_RD2;
            end
            S_RD2: begin
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (x_in <= n_wide) begin
                  j_ff     <= j_ff + LoopWidth'(1);
                  x_ff     <= x_in;
                  state_ff <= S_RD1;
               end else if (sq_in <= n_wide) begin
                  i_ff     <= i_in;
                  j_ff     <= i_in;
                  x_ff     <= sq_in;
                  sq_ff    <= sq_in;
                  state_ff <= S_RD1;
               end else begin
                  k_ff     <= '0;
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               k_ff <= k_ff + AddrWidth'(1);
               if (emit_last) begin
                  count_ff <= '0;
                  busy_ff  <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy                 = busy_ff;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data.h_value     = h_rd_ff;
   assign rsp_data.last_result = rsp_last_ff;

`include "dirichlet_convolution_engine_core_macros.svh"

   `DCE_ASSERT_NOW(a_more_words_while_busy, clock, reset, rsp_valid && !rsp_data.last_result, busy)
   `DCE_ASSERT_NOW(a_idle_after_final, clock, reset, rsp_valid && rsp_data.last_result, !busy)
   `DCE_ASSERT_NEXT(a_last_pair_starts_run, clock, reset, start && !busy && req_data.last_pair, busy)
   `DCE_ASSERT_NOW(a_pair_ordered, clock, reset, state_ff == S_ACC, (i_ff <= j_ff) && (x_ff <= n_wide))

endmodule

`default_nettype wire
